/* design/smrs_pkg.sv */
// Shared types and constants for the sorted multiset rank sum engine.
// No dependencies; used by the cell and the top level.
package smrs_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int K_W     = 24;
  localparam int SUM_W   = 64;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SUM    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_INCR   = 2'd3;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

/* design/smrs_cell.sv */
// One storage cell of the rotating table: holds one entry and takes the entry on
// d_in (its neighbor's, or the write-back at the tail) on every shift. Depends on smrs_pkg.
module smrs_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  smrs_pkg::entry_t d_in,
  output smrs_pkg::entry_t q
);
  import smrs_pkg::*;

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= d_in;
    end
  end

  assign q = entry_r;

endmodule

/* design/sorted_multiset_rank_sum_engine.sv */
// Top level of the sorted multiset rank sum engine: controller and the chain
// of smrs_cell storage cells. Depends on smrs_pkg and smrs_cell.
//
// Usage:
//   Requests arrive on the in_ channel; in_tuser carries the request kind and
//   in_tdata the value, count and k. Every request yields one result
//   transaction on the out_ channel.
//   The table is a ring of TABLE_DEPTH cells. Each request rotates the whole
//   ring once, one entry a cycle past the controller at cell 0, which merges,
//   inserts, trims or sums on the fly and writes the entry back at the tail.
//   The result goes from the ring pass through the flush and done states
//   into the output register. One request is worked on at a time, so a new
//   request is taken only once the last one has left the done state.
//   A new request is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the finished result of the next
//   request waits inside until the output register is free.
//   Reset (rst_n low, synchronous) empties the table, clears the offset and
//   drops any pending result. No clearing pass is needed.
module sorted_multiset_rank_sum_engine #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // value[31:0], item_count[47:32], k_items[71:48]
  input  logic [1:0]   in_tuser,   // req_type[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // smallest_sum[63:0], total_items[87:64],
                                   // distinct_used[96:88], table_full[97], zeros
);
  import smrs_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = COUNT_W + UW;
  localparam int MW = (TW > K_W) ? TW : K_W;

  state_t state_r, state_nxt;

  logic [1:0]         req_r;
  logic [VALUE_W-1:0] val_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [K_W-1:0]     k_r;
  logic [IW-1:0]      j_r;
  logic [UW-1:0]      used_r, used_nxt;
  logic [TW-1:0]      total_r, total_nxt;
  logic [VALUE_W-1:0] offset_r, offset_nxt;
  logic               done_r, done_nxt;
  logic               shifting_r, shifting_nxt;
  logic               full_r, full_nxt;
  logic               incr_ok_r, incr_ok_nxt;
  entry_t             hold_r, hold_nxt;
  logic [TW-1:0]      keep_r, cum_r, cum_nxt;
  logic [UW-1:0]      new_used_r, new_used_nxt;
  logic [K_W-1:0]     rem_r, rem_nxt;
  logic signed [VALUE_W+COUNT_W:0] prod_r, prod_nxt;
  logic               prod_vld_r, prod_vld_nxt;
  logic signed [SUM_W-1:0] acc_r;

  logic               out_tvalid_r;
  logic [103:0]       out_tdata_r;

  entry_t head, wb;
  entry_t chain_q [TABLE_DEPTH];
  logic   shift_en;

  logic signed [VALUE_W-1:0] eff, vin;
  logic               j_in;
  logic               j_last_used;
  logic               j_end;
  logic [COUNT_W:0]   merged;
  logic [COUNT_W-1:0] take;
  logic [MW-1:0]      k_ext, total_ext;
  logic [TW-1:0]      cum_add;
  logic [8:0]         distinct_sat;
  logic [K_W-1:0]     total_sat;

  // Ring of cells: each takes from the next one, the tail takes the write-back.
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == TABLE_DEPTH - 1) begin : g_tail
        smrs_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(wb), .q(chain_q[gi]));
      end else begin : g_body
        smrs_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(chain_q[gi+1]),
                          .q(chain_q[gi]));
      end
    end
  endgenerate

  assign head        = chain_q[0];
  assign shift_en    = (state_r == ST_PASS);
  assign eff         = $signed(head.value + offset_r);
  assign vin         = $signed(val_r);
  assign j_in        = (UW'(j_r) < used_r);
  assign j_last_used = ((UW'(j_r) + UW'(1)) == used_r);
  assign j_end       = (j_r == IW'(TABLE_DEPTH - 1));
  assign merged      = {1'b0, head.count} + {1'b0, cnt_r};
  assign take        = ((K_W'(head.count)) > rem_r) ? rem_r[COUNT_W-1:0] : head.count;
  assign cum_add     = cum_r + TW'(head.count);
  assign k_ext       = MW'(k_r);
  assign total_ext   = MW'(total_r);

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      used_r    <= '0;
      total_r   <= '0;
      offset_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      total_r  <= total_nxt;
      offset_r <= offset_nxt;
      if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    done_r     <= done_nxt;
    shifting_r <= shifting_nxt;
    full_r     <= full_nxt;
    incr_ok_r  <= incr_ok_nxt;
    hold_r     <= hold_nxt;
    cum_r      <= cum_nxt;
    new_used_r <= new_used_nxt;
    rem_r      <= rem_nxt;
    prod_r     <= prod_nxt;
    prod_vld_r <= prod_vld_nxt;
    if (state_r == ST_IDLE) begin
      j_r <= '0;
      acc_r <= '0;
      if (in_tvalid) begin
        req_r  <= in_tuser;
        val_r  <= in_tdata[31:0];
        cnt_r  <= in_tdata[47:32];
        k_r    <= in_tdata[71:48];
        keep_r <= (MW'(in_tdata[71:48]) >= total_ext) ? '0
                : TW'(total_ext - MW'(in_tdata[71:48]));
      end
    end else begin
      if (state_r == ST_PASS) begin
        j_r <= j_r + IW'(1);
      end
      if (prod_vld_r) begin
        acc_r <= acc_r + SUM_W'(prod_r);
      end
    end
    if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {6'd0, full_r, distinct_sat, total_sat,
                      (req_r == REQ_SUM) ? acc_r : {SUM_W{1'b0}}};
    end
  end

  assign distinct_sat = (UW > 9 && used_r > UW'(511)) ? 9'h1FF : 9'(used_r);
  assign total_sat    = (MW'(total_r) > MW'(24'hFF_FFFF)) ? 24'hFF_FFFF : K_W'(total_r);

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    total_nxt    = total_r;
    offset_nxt   = offset_r;
    done_nxt     = done_r;
    shifting_nxt = shifting_r;
    full_nxt     = full_r;
    incr_ok_nxt  = incr_ok_r;
    hold_nxt     = hold_r;
    cum_nxt      = cum_r;
    new_used_nxt = new_used_r;
    rem_nxt      = rem_r;
    prod_nxt     = prod_r;
    prod_vld_nxt = 1'b0;
    wb           = head;
    case (state_r)
      ST_IDLE: begin
        done_nxt     = 1'b0;
        shifting_nxt = 1'b0;
        full_nxt     = 1'b0;
        incr_ok_nxt  = 1'b0;
        cum_nxt      = '0;
        new_used_nxt = '0;
        rem_nxt      = in_tdata[71:48];
        if (in_tvalid) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        case (req_r)
          REQ_INSERT: begin
            if (cnt_r != '0) begin
              if (done_r) begin
                if (shifting_r) begin
                  wb       = hold_r;
                  hold_nxt = head;
                end
              end else if (j_in && eff < vin) begin
                wb = head;
              end else if (j_in && eff == vin) begin
                wb.count  = merged[COUNT_W] ? COUNT_MAX : merged[COUNT_W-1:0];
                total_nxt = total_r + TW'(wb.count) - TW'(head.count);
                done_nxt  = 1'b1;
              end else if (j_in || UW'(j_r) == used_r) begin
                done_nxt = 1'b1;
                if (used_r < UW'(TABLE_DEPTH)) begin
                  wb.value     = val_r - offset_r;
                  wb.count     = cnt_r;
                  hold_nxt     = head;
                  shifting_nxt = 1'b1;
                  used_nxt     = used_r + UW'(1);
                  total_nxt    = total_r + TW'(cnt_r);
                end else begin
                  full_nxt = 1'b1;
                end
              end
            end
          end
          REQ_SUM: begin
            if (j_in && rem_r != '0) begin
              prod_nxt     = eff * $signed({1'b0, take});
              prod_vld_nxt = 1'b1;
              rem_nxt      = rem_r - K_W'(take);
            end
          end
          REQ_REMOVE: begin
            if (j_in && k_r != '0) begin
              if (cum_r < keep_r) begin
                new_used_nxt = new_used_r + UW'(1);
                if (cum_add > keep_r) begin
                  wb.count = COUNT_W'(keep_r - cum_r);
                end
              end
              cum_nxt = cum_add;
            end
          end
          default: begin
            if (j_in && j_last_used && eff != $signed(VALUE_MAX)) begin
              incr_ok_nxt = 1'b1;
            end
          end
        endcase
        if (j_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // A new value above every entry of a full table finds no slot in the pass.
        if (req_r == REQ_INSERT && cnt_r != '0 && !done_r) begin
          full_nxt = 1'b1;
        end
        if (req_r == REQ_REMOVE && k_r != '0) begin
          used_nxt  = new_used_r;
          total_nxt = keep_r;
        end
        if (req_r == REQ_INCR && incr_ok_r) begin
          offset_nxt = offset_r + VALUE_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The ring pass advances one entry every cycle until its last slot.
  a_pass_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS && !j_end) |=> (state_r == ST_PASS && j_r == $past(j_r) + IW'(1)))
    else $error("ring pass did not advance");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((total_r == '0) == (used_r == '0)))
    else $error("item total and entry count disagree");

endmodule
